// ===== rtl/core/bsrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrc_pkg
// Shared types, codes and helpers of the blank synced root counter.
// ----------------------------------------------------------------------------
package bsrc_pkg;

	localparam int ACC_W  = 20;
	localparam int CNT_W  = 16;
	localparam int MODE_W = 13;
	localparam int CYC_W  = 8;
	localparam int MVAL_W = 16;
	localparam int TICK_W = 20;
	localparam int NV_W   = 21;
	localparam int KIND_W = 2;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam int QUO6_W = 18;

	localparam logic [ACC_W-1:0] ACC_MAX = 20'hFFFFF;

	// floor(x / 6) = (x * DIV6_MUL) >> DIV6_SHIFT for every 20-bit x
	localparam int DIV6_SHIFT = 23;
	localparam logic [20:0] DIV6_MUL = 21'd1398102;

	// item operations
	typedef logic [1:0] op_t;
	localparam op_t OP_ADVANCE    = 2'd0;
	localparam op_t OP_WRITE_MODE = 2'd1;
	localparam op_t OP_READ_MODE  = 2'd2;

	// timer kinds
	typedef logic [KIND_W-1:0] kind_t;
	localparam kind_t KIND_DOT    = 2'd0;
	localparam kind_t KIND_HBLANK = 2'd1;
	localparam kind_t KIND_SYS8   = 2'd2;

	// sync modes (mode bits 2:1)
	typedef logic [1:0] smode_t;
	localparam smode_t SYNC_PAUSE_IN_BLANK = 2'd0;
	localparam smode_t SYNC_RESET_AT_BLANK = 2'd1;
	localparam smode_t SYNC_COUNT_IN_BLANK = 2'd2;
	localparam smode_t SYNC_WAIT_EDGE      = 2'd3;

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_TIMER_KIND   = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_TARGET_VALUE = 1'b1;

	// mode register bit positions
	localparam int MB_SYNC   = 0;
	localparam int MB_SMODE  = 1;
	localparam int MB_RSTTGT = 3;
	localparam int MB_IRQTGT = 4;
	localparam int MB_IRQWRP = 5;
	localparam int MB_REPEAT = 6;
	localparam int MB_TOGGLE = 7;
	localparam int MB_SRC    = 8;
	localparam int MB_IRQ    = 10;
	localparam int MB_REACH  = 11;
	localparam int MB_WRAP   = 12;

	typedef struct packed {
		op_t               op;
		logic [CYC_W-1:0]  cpu_cycles;
		logic              hblank_now;
		logic              vblank_now;
		logic [MVAL_W-1:0] mode_value;
	} item_t;

	typedef struct packed {
		logic [ACC_W-1:0]  acc;
		logic [CNT_W-1:0]  count;
		logic [MODE_W-1:0] mode;
		logic              prev_hblank;
		logic              prev_vblank;
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0]  count_value;
		logic [MODE_W-1:0] mode_readback;
		logic              irq_fired;
	} result_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              fired;
		logic              pulse;
	} irq_t;

	// One interrupt request: one-shot, pulse or toggle form.
	function automatic irq_t raise_irq(input logic [MODE_W-1:0] mode);
		irq_t r;
		r.mode  = mode;
		r.fired = 1'b1;
		r.pulse = 1'b0;
		if (!mode[MB_REPEAT]) begin
			if (!mode[MB_IRQ]) begin
				r.fired = 1'b0;
			end else begin
				r.mode[MB_IRQ] = 1'b0;
			end
		end else if (mode[MB_TOGGLE]) begin
			r.mode[MB_IRQ] = ~mode[MB_IRQ];
		end else begin
			r.mode[MB_IRQ] = 1'b0;
			r.pulse        = 1'b1;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bsrc_div6.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrc_div6
// Divide a 20-bit cycle count by six: reciprocal multiply, then remainder.
// ----------------------------------------------------------------------------
module bsrc_div6 import bsrc_pkg::*; (
	input  wire logic [ACC_W-1:0]  dividend,
	output logic      [QUO6_W-1:0] quotient,
	output logic      [2:0]        remainder
);

	logic [ACC_W+21-1:0] product;
	logic [ACC_W-1:0]    times6;
	logic [ACC_W-1:0]    rem_full;

	assign product   = {21'd0, dividend} * {20'd0, DIV6_MUL};
	assign quotient  = product[ACC_W+21-1:DIV6_SHIFT];
	assign times6    = {quotient, 2'b00} + {1'b0, quotient, 1'b0};
	assign rem_full  = dividend - times6;
	assign remainder = rem_full[2:0];

endmodule
`default_nettype wire

// ===== rtl/core/bsrc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrc_step
// Next-state and result logic for one word: sync gating, clock source,
// target and wrap checks, interrupt forms, mode writes and reads.
// ----------------------------------------------------------------------------
module bsrc_step import bsrc_pkg::*; (
	input  wire item_t            item,
	input  wire state_t           cur,
	input  wire kind_t            timer_kind,
	input  wire logic [CNT_W-1:0] target_value,
	output state_t                nxt,
	output result_t               res
);

	kind_t             kind;
	logic              lvl;
	logic              prev;
	logic [ACC_W:0]    acc_sum;
	logic [ACC_W-1:0]  acc_sat;
	logic [ACC_W-1:0]  acc_sync;
	logic [CNT_W-1:0]  cnt_sync;
	logic [MODE_W-1:0] mode_sync;
	logic              run_src;
	logic [QUO6_W-1:0] quo6;
	logic [2:0]        rem6;

	assign kind = timer_kind[1] ? KIND_SYS8 : timer_kind;
	assign lvl  = (kind == KIND_DOT) ? item.hblank_now : item.vblank_now;
	assign prev = (kind == KIND_DOT) ? cur.prev_hblank : cur.prev_vblank;
	assign acc_sum = {1'b0, cur.acc} + {{(ACC_W+1-CYC_W){1'b0}}, item.cpu_cycles};
	assign acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

	// sync gating
	always_comb begin
		acc_sync  = acc_sat;
		cnt_sync  = cur.count;
		mode_sync = cur.mode;
		run_src   = 1'b1;
		if (cur.mode[MB_SYNC]) begin
			if (kind == KIND_SYS8) begin
				if (cur.mode[MB_SMODE+:2] == SYNC_PAUSE_IN_BLANK ||
					cur.mode[MB_SMODE+:2] == SYNC_WAIT_EDGE) begin
					acc_sync = '0;
					run_src  = 1'b0;
				end
			end else begin
				unique case (cur.mode[MB_SMODE+:2])
					SYNC_PAUSE_IN_BLANK: begin
						if (lvl) run_src = 1'b0;
					end
					SYNC_RESET_AT_BLANK: begin
						if (lvl) begin
							cnt_sync = '0;
							acc_sync = '0;
							run_src  = 1'b0;
						end
					end
					SYNC_COUNT_IN_BLANK: begin
						if (!lvl) begin
							run_src = 1'b0;
						end else begin
							cnt_sync = '0;
							acc_sync = '0;
						end
					end
					default: begin
						if (!prev && lvl) mode_sync[MB_SYNC] = 1'b0;
						else run_src = 1'b0;
					end
				endcase
			end
		end
	end

	bsrc_div6 u_div6 (
		.dividend  (acc_sync),
		.quotient  (quo6),
		.remainder (rem6)
	);

	logic [TICK_W-1:0] ticks;
	logic [ACC_W-1:0]  acc_src;
	logic [NV_W-1:0]   nv;
	logic [MODE_W-1:0] mode_w;
	logic              fired;
	logic              pulse;
	irq_t              irq_a;
	irq_t              irq_b;

	always_comb begin
		nxt     = cur;
		res     = '0;
		ticks   = '0;
		acc_src = '0;
		nv      = '0;
		mode_w  = cur.mode;
		fired   = 1'b0;
		pulse   = 1'b0;
		irq_a   = '0;
		irq_b   = '0;
		case (item.op)
			OP_ADVANCE: begin
				nxt.prev_hblank = item.hblank_now;
				nxt.prev_vblank = item.vblank_now;
				nxt.acc         = acc_sync;
				nxt.count       = cnt_sync;
				nxt.mode        = mode_sync;
				if (run_src) begin
					// clock source: cycles to ticks
					if (kind == KIND_DOT && mode_sync[MB_SRC]) begin
						ticks   = {{(TICK_W-QUO6_W){1'b0}}, quo6};
						acc_src = {{(ACC_W-3){1'b0}}, rem6};
					end else if (kind == KIND_HBLANK && mode_sync[MB_SRC]) begin
						ticks   = {{(TICK_W-1){1'b0}}, !cur.prev_hblank && item.hblank_now};
						acc_src = '0;
					end else if (kind == KIND_SYS8 && mode_sync[MB_SRC+1]) begin
						ticks   = {3'b000, acc_sync[ACC_W-1:3]};
						acc_src = {{(ACC_W-3){1'b0}}, acc_sync[2:0]};
					end else begin
						ticks   = acc_sync;
						acc_src = '0;
					end
					nv     = {{(NV_W-CNT_W){1'b0}}, cnt_sync} + {1'b0, ticks};
					mode_w = mode_sync;
					// target crossing
					if (cnt_sync < target_value && nv >= {5'd0, target_value}) begin
						mode_w[MB_REACH] = 1'b1;
						if (mode_w[MB_RSTTGT]) nv = '0;
						if (mode_w[MB_IRQTGT]) begin
							irq_a  = raise_irq(mode_w);
							mode_w = irq_a.mode;
							fired  = irq_a.fired;
							pulse  = irq_a.pulse;
						end
					end
					// wrap past 0xFFFF
					if (nv[NV_W-1:CNT_W] != '0) begin
						mode_w[MB_WRAP] = 1'b1;
						nv[NV_W-1:CNT_W] = '0;
						if (!mode_w[MB_RSTTGT]) nv = '0;
						if (mode_w[MB_IRQWRP]) begin
							irq_b  = raise_irq(mode_w);
							mode_w = irq_b.mode;
							fired  = fired | irq_b.fired;
							pulse  = pulse | irq_b.pulse;
						end
					end
					if (pulse) mode_w[MB_IRQ] = 1'b1;
					nxt.acc   = acc_src;
					nxt.count = nv[CNT_W-1:0];
					nxt.mode  = mode_w;
				end
			end
			OP_WRITE_MODE: begin
				nxt.mode  = {cur.mode[MB_WRAP:MB_REACH], 1'b1, item.mode_value[9:0]};
				nxt.count = '0;
			end
			OP_READ_MODE: begin
				res.mode_readback = cur.mode;
				nxt.mode[MB_WRAP:MB_REACH] = 2'b00;
			end
			default: begin
			end
		endcase
		res.count_value = nxt.count;
		res.irq_fired   = fired;
	end

endmodule
`default_nettype wire

// ===== rtl/core/blank_synced_root_counter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// blank_synced_root_counter_unit
// One 16-bit root counter (dot-clock, hblank or system clock / 8 kind) with
// blank sync modes, target and wrap flags and interrupt forms.
// ----------------------------------------------------------------------------
// Each input word is an operation (advance, write mode, read mode) and gives
// exactly one result word: the count after the operation, the mode readback
// (read words only, else zero) and an interrupt flag. The unit takes one word
// per clock while s_axis_tready is high. The word is held in an input
// register, then one pass of next-state logic updates the counter state and
// loads the result register, whose valid flag drives m_axis_tvalid. That
// pass, with the divide-by-six reciprocal multiply feeding the target and
// wrap compares, sets the clock period. The result register and the input
// register are parted by the m_axis handshake: a new word is taken while an
// unread result waits, and s_axis_tready drops only when both registers are
// full and m_axis_tready is low. Write configuration only while no word is in
// flight.
// ----------------------------------------------------------------------------
module blank_synced_root_counter_unit import bsrc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// input words
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// [7:0] cpu_cycles, [8] hblank_now, [9] vblank_now, [25:10] mode_value
	input  wire logic [31:0]           s_axis_tdata,
	// [1:0] operation
	input  wire logic [1:0]            s_axis_tuser,
	// result words
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// [15:0] count_value, [28:16] mode_readback, [29] irq_fired
	output logic [31:0]                m_axis_tdata
);

	item_t             item_s1;
	logic              valid_s1;
	result_t           result_s2;
	logic              valid_s2;
	state_t            state_q;
	kind_t             kind_q;
	logic [CNT_W-1:0]  target_q;
	state_t            state_nxt;
	result_t           result_nxt;
	logic              advance_s1;
	logic              in_take;

	// Advance the input register whenever the result slot frees up.
	assign advance_s1    = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance_s1;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_DOT;
			target_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_TIMER_KIND:   kind_q   <= cfg_wdata[KIND_W-1:0];
				REG_TARGET_VALUE: target_q <= cfg_wdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register: hold the word until the pass consumes it.
	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.op         <= s_axis_tuser;
			item_s1.cpu_cycles <= s_axis_tdata[7:0];
			item_s1.hblank_now <= s_axis_tdata[8];
			item_s1.vblank_now <= s_axis_tdata[9];
			item_s1.mode_value <= s_axis_tdata[25:10];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Single pass of next-state logic.
	bsrc_step u_step (
		.item         (item_s1),
		.cur          (state_q),
		.timer_kind   (kind_q),
		.target_value (target_q),
		.nxt          (state_nxt),
		.res          (result_nxt)
	);

	// Counter state: update once per consumed word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result register: hold until the sink takes it.
	always_ff @(posedge clk) begin
		if (valid_s1 && advance_s1) begin
			result_s2 <= result_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (valid_s1 && advance_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, result_s2.irq_fired, result_s2.mode_readback,
		result_s2.count_value};

endmodule
`default_nettype wire

// ===== rtl/core/bsrc_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsrc_monitor
// Port-level assertions for the root counter unit, bound to the top level.
// ----------------------------------------------------------------------------
module bsrc_monitor import bsrc_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tready,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [31:0]           m_axis_tdata
);

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// A result word leaves only through a handshake.
	a_out_leave: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_axis_tvalid) |-> $past(m_axis_tready))
		else $error("result word dropped without handshake");

	// With the result slot empty the input side never stalls.
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result slot");

	// Interrupts come only from advance words, which carry no readback.
	a_irq_no_rb: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[29] |-> m_axis_tdata[28:16] == '0)
		else $error("interrupt flagged on a mode read");

endmodule

bind blank_synced_root_counter_unit bsrc_monitor u_bsrc_monitor (.*);
`default_nettype wire

// ===== tb/blank_synced_root_counter_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blank_synced_root_counter_unit_tb
// Self-checking bench for the root counter unit. A clocked driver sends
// operation words from a queue, and a bit-accurate model of the counter
// predicts each result word. A clocked monitor compares every returned word
// with the oldest prediction. Phases cover all timer kinds, extreme targets,
// long blank waits, a long run that wraps the count and several idle patterns.
// ----------------------------------------------------------------------------
module blank_synced_root_counter_unit_tb;
	import bsrc_pkg::*;

	// operation code the unit must ignore
	localparam op_t OP_UNUSED = 2'd3;
	// undocumented kind, behaves as system clock / 8
	localparam kind_t KIND_SYS8_ALIAS = 2'd3;

	localparam int CLK_HALF       = 5;
	localparam int RESET_CYCLES   = 8;
	localparam int DRAIN_CYCLES   = 8;
	localparam int RX_HOLD_CYCLES = 200;
	localparam int PHASE_WORDS    = 70;
	localparam int WRAP_WORDS     = 260;
	localparam int TIMEOUT_NS     = 5_000_000;

	// ------------------------------------------------------------------------
	// DUT signals, inputs driven to known values from time zero
	// ------------------------------------------------------------------------
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_wr_en     = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// [7:0] cpu_cycles, [8] hblank_now, [9] vblank_now, [25:10] mode_value
	logic [31:0]           s_axis_tdata  = '0;
	// [1:0] operation
	logic [1:0]            s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// [15:0] count_value, [28:16] mode_readback, [29] irq_fired
	logic [31:0]           m_axis_tdata;

	blank_synced_root_counter_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #(CLK_HALF) clk = ~clk;

	// ------------------------------------------------------------------------
	// Counter model state: a private copy of registers and counter state
	// ------------------------------------------------------------------------
	kind_t             kind_cfg   = KIND_DOT;
	logic [CNT_W-1:0]  target_cfg = '0;
	logic [ACC_W-1:0]  acc_q      = '0;
	logic [CNT_W-1:0]  count_q    = '0;
	logic [MODE_W-1:0] mode_q     = '0;
	logic              hb_prev_q  = 1'b0;
	logic              vb_prev_q  = 1'b0;
	bit                pulse_due  = 1'b0;

	// queues between stimulus, driver and monitor
	item_t   words_to_send[$];
	result_t results_due[$];
	item_t   word_on_bus;
	bit      word_offered = 1'b0;
	result_t due;

	// stimulus state: current blank levels of the generated video timing
	bit hb_lvl = 1'b0;
	bit vb_lvl = 1'b0;

	// idle control
	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	bit rx_hold         = 1'b0;
	int rx_holds_wanted = 0;
	int rx_holds_done   = 0;

	// statistics
	int words_queued    = 0;
	int words_accepted  = 0;
	int results_checked = 0;
	int irqs_expected   = 0;
	int target_hits     = 0;
	int wraps           = 0;
	int mismatches      = 0;

	// One interrupt request in the form the mode bits select.
	function automatic bit request_irq();
		if (!mode_q[MB_REPEAT]) begin
			// one-shot: fire only while the line is still high
			if (!mode_q[MB_IRQ]) return 1'b0;
			mode_q[MB_IRQ] = 1'b0;
		end else if (mode_q[MB_TOGGLE]) begin
			mode_q[MB_IRQ] = ~mode_q[MB_IRQ];
		end else begin
			// pulse: line drops now and reads high again after the word
			mode_q[MB_IRQ] = 1'b0;
			pulse_due = 1'b1;
		end
		return 1'b1;
	endfunction

	// Add ticks to the count; handle target crossing and 16-bit wrap.
	function automatic bit add_counter_ticks(input logic [ACC_W-1:0] ticks);
		logic [NV_W-1:0] sum;
		bit              fired;
		fired = 1'b0;
		sum   = NV_W'(count_q) + NV_W'(ticks);
		// target 0 can never be crossed: old count must be below it
		if (count_q < target_cfg && sum >= target_cfg) begin
			target_hits++;
			mode_q[MB_REACH] = 1'b1;
			if (mode_q[MB_RSTTGT]) sum = '0;
			if (mode_q[MB_IRQTGT]) fired |= request_irq();
		end
		// at most one logical wrap per word; without reset-on-target it lands on 0
		if (sum[NV_W-1:CNT_W] != '0) begin
			wraps++;
			mode_q[MB_WRAP] = 1'b1;
			sum[NV_W-1:CNT_W] = '0;
			if (!mode_q[MB_RSTTGT]) sum = '0;
			if (mode_q[MB_IRQWRP]) fired |= request_irq();
		end
		count_q = sum[CNT_W-1:0];
		return fired;
	endfunction

	// Advance word: accumulate, apply blank sync, then convert by clock source.
	function automatic bit step_counter(input logic [CYC_W-1:0] cycles,
			input logic hb, input logic vb);
		kind_t            kind;
		smode_t           smode;
		logic [1:0]       src;
		logic [ACC_W:0]   acc_sum;
		logic             lvl;
		logic             prev;
		logic [ACC_W-1:0] ticks;
		kind  = (kind_cfg >= KIND_SYS8) ? KIND_SYS8 : kind_cfg;
		smode = mode_q[MB_SMODE +: 2];
		src   = mode_q[MB_SRC +: 2];

		// accumulate even while paused; clamp at the 20-bit ceiling
		acc_sum = {1'b0, acc_q} + (ACC_W+1)'(cycles);
		if (acc_sum > ACC_MAX) begin
			acc_q = ACC_MAX;
		end else begin
			acc_q = acc_sum[ACC_W-1:0];
		end

		if (mode_q[MB_SYNC]) begin
			if (kind == KIND_SYS8) begin
				if (smode == SYNC_PAUSE_IN_BLANK || smode == SYNC_WAIT_EDGE) begin
					acc_q = '0;
					return 1'b0;
				end
			end else begin
				// dot-clock timer follows hblank, hblank timer follows vblank
				lvl  = (kind == KIND_DOT) ? hb : vb;
				prev = (kind == KIND_DOT) ? hb_prev_q : vb_prev_q;
				case (smode)
				SYNC_PAUSE_IN_BLANK: begin
					if (lvl) return 1'b0;
				end
				SYNC_RESET_AT_BLANK: begin
					if (lvl) begin
						count_q = '0;
						acc_q   = '0;
						return 1'b0;
					end
				end
				SYNC_COUNT_IN_BLANK: begin
					if (!lvl) return 1'b0;
					count_q = '0;
					acc_q   = '0;
				end
				default: begin
					// wait for a rising blank edge, then run free
					if (!prev && lvl) mode_q[MB_SYNC] = 1'b0;
					else return 1'b0;
				end
				endcase
			end
		end

		if (kind == KIND_DOT && src[0]) begin
			ticks = acc_q / ACC_W'(6);
			acc_q = acc_q % ACC_W'(6);
			return add_counter_ticks(ticks);
		end
		if (kind == KIND_HBLANK && src[0]) begin
			acc_q = '0;
			if (!hb_prev_q && hb) return add_counter_ticks(ACC_W'(1));
			return 1'b0;
		end
		if (kind == KIND_SYS8 && src[1]) begin
			ticks = acc_q / ACC_W'(8);
			acc_q = acc_q % ACC_W'(8);
			return add_counter_ticks(ticks);
		end
		ticks = acc_q;
		acc_q = '0;
		return add_counter_ticks(ticks);
	endfunction

	// Apply one accepted word to the model and return its result word.
	function automatic result_t apply_word(input item_t w);
		result_t r;
		r = '0;
		pulse_due = 1'b0;
		case (w.op)
		OP_ADVANCE: begin
			r.irq_fired = step_counter(w.cpu_cycles, w.hblank_now, w.vblank_now);
			hb_prev_q = w.hblank_now;
			vb_prev_q = w.vblank_now;
			if (pulse_due) mode_q[MB_IRQ] = 1'b1;
		end
		OP_WRITE_MODE: begin
			// take the writable low bits, raise the IRQ line, keep the flags
			mode_q[MB_IRQ-1:0] = w.mode_value[MB_IRQ-1:0];
			mode_q[MB_IRQ]     = 1'b1;
			count_q            = '0;
		end
		OP_READ_MODE: begin
			r.mode_readback  = mode_q;
			mode_q[MB_REACH] = 1'b0;
			mode_q[MB_WRAP]  = 1'b0;
		end
		default: begin
		end
		endcase
		r.count_value = count_q;
		if (r.irq_fired) irqs_expected++;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic item_t make_word(input op_t op, input int cycles,
			input int hb, input int vb, input int mv);
		item_t w;
		w.op         = op;
		w.cpu_cycles = cycles[CYC_W-1:0];
		w.hblank_now = hb[0];
		w.vblank_now = vb[0];
		w.mode_value = mv[MVAL_W-1:0];
		return w;
	endfunction

	// cycle counts biased toward the ends and toward small steps
	function automatic int random_cycles();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) return 0;
		if (pick == 1) return 255;
		if (pick < 5) return $urandom_range(15);
		return $urandom_range(255);
	endfunction

	task automatic send_word(input item_t w);
		words_to_send.push_back(w);
		words_queued++;
	endtask

	// Mode write followed by a mix of advances with moving blank levels, reads,
	// further writes and the odd ignored operation. Unused fields carry noise.
	task automatic queue_session(input int len);
		int pick;
		send_word(make_word(OP_WRITE_MODE, $urandom, $urandom, $urandom, $urandom));
		repeat (len) begin
			pick = $urandom_range(99);
			if (pick < 78) begin
				if ($urandom_range(99) < 35) hb_lvl = ~hb_lvl;
				if ($urandom_range(99) < 20) vb_lvl = ~vb_lvl;
				send_word(make_word(OP_ADVANCE, random_cycles(), hb_lvl, vb_lvl, $urandom));
			end else if (pick < 88) begin
				send_word(make_word(OP_READ_MODE, $urandom, $urandom, $urandom, $urandom));
			end else if (pick < 96) begin
				send_word(make_word(OP_WRITE_MODE, $urandom, $urandom, $urandom,
					$urandom));
			end else begin
				send_word(make_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
			end
		end
	endtask

	// Arm wait-for-edge sync, hold both blanks low for len advances so the
	// accumulator piles up, then release on a rising edge: large tick bursts.
	task automatic queue_blank_wait(input int len, input int lo, input int hi);
		logic [MVAL_W-1:0] mv;
		mv = MVAL_W'($urandom);
		mv[MB_SYNC] = 1'b1;
		mv[MB_SMODE +: 2] = SYNC_WAIT_EDGE;
		send_word(make_word(OP_WRITE_MODE, $urandom, $urandom, $urandom, mv));
		repeat (len) send_word(make_word(OP_ADVANCE, $urandom_range(hi, lo), 1'b0, 1'b0,
			$urandom));
		send_word(make_word(OP_ADVANCE, $urandom_range(255), 1'b1, 1'b1, $urandom));
		hb_lvl = 1'b1;
		vb_lvl = 1'b1;
		repeat (3) send_word(make_word(OP_ADVANCE, random_cycles(), hb_lvl, vb_lvl,
			$urandom));
		send_word(make_word(OP_READ_MODE, $urandom, $urandom, $urandom, $urandom));
	endtask

	// Write one register while the unit is idle and mirror it in the model.
	task automatic program_reg(input logic [CFG_ADDR_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == REG_TIMER_KIND) begin
			kind_cfg = value[KIND_W-1:0];
		end else begin
			target_cfg = value[CNT_W-1:0];
		end
	endtask

	// Wait until every queued word went in and every result came back.
	task automatic drain();
		while (words_to_send.size() != 0 || word_offered || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 25)
			$display("mismatch on %s in result %0d: got 0x%0h, expected 0x%0h",
				what, results_checked, got, want);
	endtask

	// ------------------------------------------------------------------------
	// Driver: offer queued words, predict each one the unit accepts
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				results_due.push_back(apply_word(word_on_bus));
				words_accepted++;
				word_offered = 1'b0;
			end
			// hold the current word until it is taken, then pick the next or idle
			if (!s_axis_tvalid || s_axis_tready) begin
				if (words_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					word_on_bus   = words_to_send.pop_front();
					word_offered  = 1'b1;
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {6'b0, word_on_bus.mode_value, word_on_bus.vblank_now,
						word_on_bus.hblank_now, word_on_bus.cpu_cycles};
					s_axis_tuser  <= word_on_bus.op;
				end else begin
					// idle: drop valid and scramble the bus
					s_axis_tvalid <= 1'b0;
					s_axis_tdata  <= $urandom;
					s_axis_tuser  <= 2'($urandom);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: stall at random, compare each result word with the oldest one due
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (results_due.size() == 0) begin
					report_mismatch("word with nothing due", m_axis_tdata, 0);
				end else begin
					due = results_due.pop_front();
					results_checked++;
					if (m_axis_tdata[15:0] !== due.count_value)
						report_mismatch("count_value", m_axis_tdata[15:0], due.count_value);
					if (m_axis_tdata[28:16] !== due.mode_readback)
						report_mismatch("mode_readback", m_axis_tdata[28:16],
							due.mode_readback);
					if (m_axis_tdata[29] !== due.irq_fired)
						report_mismatch("irq_fired", m_axis_tdata[29], due.irq_fired);
				end
			end
			m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Long output hold-off, counted here so the sender keeps pushing meanwhile.
	always begin
		@(posedge clk);
		if (rx_holds_done != rx_holds_wanted) begin
			rx_hold <= 1'b1;
			repeat (RX_HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
			rx_holds_done++;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin : sequencer
		int phase;
		int target;
		int phase_start;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed words: field extremes, every operation, each IRQ form
		program_reg(REG_TIMER_KIND, KIND_DOT);
		program_reg(REG_TARGET_VALUE, 5);
		send_word(make_word(OP_ADVANCE, 0, 1'b0, 1'b0, 16'h0000));
		send_word(make_word(OP_ADVANCE, 255, 1'b1, 1'b1, 16'hFFFF));
		send_word(make_word(OP_READ_MODE, 0, 1'b0, 1'b0, 16'h0000));
		send_word(make_word(OP_UNUSED, 255, 1'b1, 1'b1, 16'hFFFF));
		// all writable bits: wait-for-edge sync, toggle IRQ, divide by six
		send_word(make_word(OP_WRITE_MODE, 255, 1'b1, 1'b1, 16'hFFFF));
		send_word(make_word(OP_ADVANCE, 30, 1'b0, 1'b0, 16'h0000));
		send_word(make_word(OP_ADVANCE, 200, 1'b1, 1'b1, 16'h0000));
		send_word(make_word(OP_ADVANCE, 255, 1'b0, 1'b0, 16'h0000));
		send_word(make_word(OP_READ_MODE, 0, 1'b0, 1'b0, 16'h0000));
		// one-shot IRQ on target, once without and once with reset on target
		send_word(make_word(OP_WRITE_MODE, 0, 1'b0, 1'b0, 16'h0010));
		send_word(make_word(OP_ADVANCE, 255, 1'b0, 1'b0, 16'h0000));
		send_word(make_word(OP_WRITE_MODE, 0, 1'b0, 1'b0, 16'h0018));
		send_word(make_word(OP_ADVANCE, 6, 1'b0, 1'b0, 16'h0000));
		send_word(make_word(OP_ADVANCE, 6, 1'b0, 1'b0, 16'h0000));
		// pulse IRQ with reset on target fires on every crossing
		send_word(make_word(OP_WRITE_MODE, 0, 1'b0, 1'b0, 16'h0058));
		send_word(make_word(OP_ADVANCE, 9, 1'b0, 1'b0, 16'h0000));
		send_word(make_word(OP_ADVANCE, 9, 1'b0, 1'b0, 16'h0000));
		send_word(make_word(OP_READ_MODE, 0, 1'b0, 1'b0, 16'h0000));
		// only the ignored upper mode bits set
		send_word(make_word(OP_WRITE_MODE, 0, 1'b0, 1'b0, 16'hFC00));
		send_word(make_word(OP_ADVANCE, 255, 1'b0, 1'b1, 16'h0000));
		send_word(make_word(OP_READ_MODE, 0, 1'b0, 1'b0, 16'h0000));
		send_word(make_word(OP_UNUSED, 0, 1'b0, 1'b0, 16'h0000));
		drain();

		// random phases: every kind, target extremes, each idle pattern
		for (phase = 0; phase < 8; phase++) begin
			case (phase)
			0: target = 16'hFFFF;
			1, 7: target = 0;
			6: target = 16'hFFFF;
			2, 4, 5: target = $urandom_range(400, 1);
			default: target = $urandom_range(16'hFFFF);
			endcase
			program_reg(REG_TIMER_KIND, (phase % 4 == 3) ? KIND_SYS8_ALIAS : phase % 4);
			program_reg(REG_TARGET_VALUE, target);
			case (phase % 4)
			0: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct  = 51;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct  = 0;
				recv_stall_pct = 51;
			end
			default: begin
				send_idle_pct  = 11;
				recv_stall_pct = 11;
			end
			endcase
			phase_start = words_queued;
			while (words_queued - phase_start < PHASE_WORDS) begin
				if ($urandom_range(3) == 0) queue_blank_wait($urandom_range(60, 10), 0, 255);
				else queue_session($urandom_range(40, 8));
			end
			drain();
		end

		// pressure: hold the output for a long stretch while words keep coming,
		// then pause the sender until everything is back and go on
		program_reg(REG_TIMER_KIND, KIND_DOT);
		program_reg(REG_TARGET_VALUE, $urandom_range(300, 1));
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		rx_holds_wanted++;
		queue_session(40);
		drain();
		queue_session(30);
		drain();

		// long free run with pulse IRQs: cross target 0xFFFF, then wrap past it
		program_reg(REG_TARGET_VALUE, 16'hFFFF);
		send_word(make_word(OP_WRITE_MODE, 0, 1'b0, 1'b0, 16'h0070));
		repeat (WRAP_WORDS) send_word(make_word(OP_ADVANCE, 255, 1'b0, 1'b0, 16'h0000));
		send_word(make_word(OP_READ_MODE, 0, 1'b0, 1'b0, 16'h0000));
		drain();

		$display("ran %0d words, checked %0d results: %0d interrupts, %0d target hits, %0d wraps",
			words_accepted, results_checked, irqs_expected, target_hits, wraps);
		$display("covered all timer kinds, targets 0 and 0xFFFF, blank waits, long stalls");
		if (mismatches == 0) begin
			$display("blank_synced_root_counter_unit_tb OK");
		end else begin
			$display("blank_synced_root_counter_unit_tb NOT OK");
		end
		$finish;
	end

	// Watchdog: the slowest correct run ends far earlier.
	initial begin
		#(TIMEOUT_NS);
		$display("blank_synced_root_counter_unit_tb NOT OK");
		$finish;
	end

endmodule

// ===== blank_synced_root_counter_unit.f =====
rtl/core/bsrc_pkg.sv
rtl/core/bsrc_div6.sv
rtl/core/bsrc_step.sv
rtl/core/blank_synced_root_counter_unit.sv
rtl/core/bsrc_monitor.sv
tb/blank_synced_root_counter_unit_tb.sv
